// ===== src/sqltl_pkg.sv =====
// ----------------------------------------------------------------------------
// sqltl_pkg
// Shared types, codes and character class functions of the SQL token lexer.
// ----------------------------------------------------------------------------
package sqltl_pkg;

    localparam int MODE_W = 4;

    localparam logic [MODE_W-1:0] M_IDLE       = 4'd0;
    localparam logic [MODE_W-1:0] M_IDENT      = 4'd1;
    localparam logic [MODE_W-1:0] M_NUMBER     = 4'd2;
    localparam logic [MODE_W-1:0] M_SIGN       = 4'd3;
    localparam logic [MODE_W-1:0] M_STRING     = 4'd4;
    localparam logic [MODE_W-1:0] M_STRING_ESC = 4'd5;
    localparam logic [MODE_W-1:0] M_GT         = 4'd6;
    localparam logic [MODE_W-1:0] M_LT         = 4'd7;
    localparam logic [MODE_W-1:0] M_BANG       = 4'd8;
    localparam logic [MODE_W-1:0] M_HALT       = 4'd9;

    localparam logic [2:0] K_IDENT  = 3'd0;
    localparam logic [2:0] K_NUMBER = 3'd1;
    localparam logic [2:0] K_STRING = 3'd2;
    localparam logic [2:0] K_SYMBOL = 3'd3;
    localparam logic [2:0] K_END    = 3'd4;
    localparam logic [2:0] K_ERROR  = 3'd5;

    localparam logic [3:0] S_COMMA  = 4'd0;
    localparam logic [3:0] S_LPAREN = 4'd1;
    localparam logic [3:0] S_RPAREN = 4'd2;
    localparam logic [3:0] S_DOT    = 4'd3;
    localparam logic [3:0] S_STAR   = 4'd4;
    localparam logic [3:0] S_EQ     = 4'd5;
    localparam logic [3:0] S_GT     = 4'd6;
    localparam logic [3:0] S_LT     = 4'd7;
    localparam logic [3:0] S_GE     = 4'd8;
    localparam logic [3:0] S_LE     = 4'd9;
    localparam logic [3:0] S_NE_BANG  = 4'd10;
    localparam logic [3:0] S_NE_ANGLE = 4'd11;

    localparam logic [1:0] E_NONE      = 2'd0;
    localparam logic [1:0] E_INVALID   = 2'd1;
    localparam logic [1:0] E_UNTERM    = 2'd2;
    localparam logic [1:0] E_TOO_LONG  = 2'd3;

    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_COMMA      = 8'h2C;
    localparam logic [7:0] CH_LPAREN     = 8'h28;
    localparam logic [7:0] CH_RPAREN     = 8'h29;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_EQ         = 8'h3D;
    localparam logic [7:0] CH_GT         = 8'h3E;
    localparam logic [7:0] CH_LT         = 8'h3C;
    localparam logic [7:0] CH_BANG       = 8'h21;
    localparam logic [7:0] CH_SQUOTE     = 8'h27;
    localparam logic [7:0] CH_DQUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH  = 8'h5C;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  sym;
        logic [15:0] start;
        logic [15:0] len;
        logic        frac;
        logic [1:0]  err;
        logic        last;
    } result_t;

    function automatic result_t make_res(logic [2:0] kind, logic [3:0] sym,
                                         logic [15:0] start, logic [15:0] len,
                                         logic frac, logic [1:0] err);
        result_t r;
        r.kind  = kind;
        r.sym   = sym;
        r.start = start;
        r.len   = len;
        r.frac  = frac;
        r.err   = err;
        r.last  = 1'b0;
        return r;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_word(logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == CH_UNDERSCORE);
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

endpackage

// ===== src/sqltl_step.sv =====
// ----------------------------------------------------------------------------
// sqltl_step
// Next-state and token logic for one query byte or end mark.
// ----------------------------------------------------------------------------
module sqltl_step #(
    parameter int POSITION_BITS = 16
) (
    input  logic                        action,
    input  logic [7:0]                  char_code,
    input  logic [sqltl_pkg::MODE_W-1:0] mode,
    input  logic [POSITION_BITS-1:0]    tstart,
    input  logic [POSITION_BITS-1:0]    pos,
    input  logic                        seen_dot,
    input  logic                        open_quote,
    output logic [sqltl_pkg::MODE_W-1:0] mode_next,
    output logic [POSITION_BITS-1:0]    tstart_next,
    output logic [POSITION_BITS-1:0]    pos_next,
    output logic                        seen_dot_next,
    output logic                        open_quote_next,
    output logic [1:0]                  res_count,
    output sqltl_pkg::result_t          res0,
    output sqltl_pkg::result_t          res1
);
    import sqltl_pkg::*;

    logic        first_v;
    logic        second_v;
    result_t     first;
    result_t     second;
    logic        again;
    logic [15:0] len16;
    logic [15:0] tstart16;
    logic [15:0] pos16;
    logic [7:0]  close_quote;
    logic        sym_hit;
    logic [3:0]  sym_code;

    assign len16       = 16'(pos - tstart);
    assign tstart16    = 16'(tstart);
    assign pos16       = 16'(pos);
    assign close_quote = open_quote ? CH_DQUOTE : CH_SQUOTE;

    always_comb
    begin
        sym_hit  = 1'b1;
        sym_code = S_COMMA;
        unique case (char_code)
            CH_COMMA:  sym_code = S_COMMA;
            CH_LPAREN: sym_code = S_LPAREN;
            CH_RPAREN: sym_code = S_RPAREN;
            CH_DOT:    sym_code = S_DOT;
            CH_STAR:   sym_code = S_STAR;
            CH_EQ:     sym_code = S_EQ;
            default:   sym_hit  = 1'b0;
        endcase
    end

    always_comb
    begin
        mode_next       = mode;
        tstart_next     = tstart;
        pos_next        = pos;
        seen_dot_next   = seen_dot;
        open_quote_next = open_quote;
        first_v         = 1'b0;
        second_v        = 1'b0;
        first           = '0;
        second          = '0;
        again           = 1'b0;
        if (action)
        begin
            unique case (mode)
                M_IDENT:
                begin
                    first_v = 1'b1;
                    first   = make_res(K_IDENT, S_COMMA, tstart16, len16, 1'b0, E_NONE);
                end
                M_NUMBER:
                begin
                    first_v = 1'b1;
                    first   = make_res(K_NUMBER, S_COMMA, tstart16, len16, seen_dot, E_NONE);
                end
                M_GT:
                begin
                    first_v = 1'b1;
                    first   = make_res(K_SYMBOL, S_GT, tstart16, 16'd1, 1'b0, E_NONE);
                end
                M_LT:
                begin
                    first_v = 1'b1;
                    first   = make_res(K_SYMBOL, S_LT, tstart16, 16'd1, 1'b0, E_NONE);
                end
                M_SIGN, M_BANG:
                begin
                    first_v = 1'b1;
                    first   = make_res(K_ERROR, S_COMMA, tstart16, 16'd0, 1'b0, E_INVALID);
                end
                M_STRING, M_STRING_ESC:
                begin
                    first_v = 1'b1;
                    first   = make_res(K_ERROR, S_COMMA, tstart16, 16'd0, 1'b0, E_UNTERM);
                end
                default:
                begin
                end
            endcase
            second_v        = 1'b1;
            second          = make_res(K_END, S_COMMA, pos16, 16'd0, 1'b0, E_NONE);
            mode_next       = M_IDLE;
            tstart_next     = '0;
            pos_next        = '0;
            seen_dot_next   = 1'b0;
            open_quote_next = 1'b0;
        end
        else if (mode == M_HALT)
        begin
        end
        else if (&pos)
        begin
            second_v  = 1'b1;
            second    = make_res(K_ERROR, S_COMMA, pos16, 16'd0, 1'b0, E_TOO_LONG);
            mode_next = M_HALT;
        end
        else
        begin
            unique case (mode)
                M_IDENT:
                begin
                    if (!is_word(char_code))
                    begin
                        first_v   = 1'b1;
                        first     = make_res(K_IDENT, S_COMMA, tstart16, len16, 1'b0, E_NONE);
                        mode_next = M_IDLE;
                        again     = 1'b1;
                    end
                end
                M_SIGN:
                begin
                    if (is_digit(char_code))
                    begin
                        mode_next = M_NUMBER;
                    end
                    else
                    begin
                        second_v  = 1'b1;
                        second    = make_res(K_ERROR, S_COMMA, tstart16, 16'd0, 1'b0,
                                             E_INVALID);
                        mode_next = M_HALT;
                    end
                end
                M_NUMBER:
                begin
                    if (is_digit(char_code))
                    begin
                    end
                    else if ((char_code == CH_DOT) && !seen_dot)
                    begin
                        seen_dot_next = 1'b1;
                    end
                    else
                    begin
                        first_v   = 1'b1;
                        first     = make_res(K_NUMBER, S_COMMA, tstart16, len16, seen_dot,
                                             E_NONE);
                        mode_next = M_IDLE;
                        again     = 1'b1;
                    end
                end
                M_STRING:
                begin
                    if (char_code == close_quote)
                    begin
                        first_v   = 1'b1;
                        first     = make_res(K_STRING, S_COMMA, tstart16, len16, 1'b0, E_NONE);
                        mode_next = M_IDLE;
                    end
                    else if (char_code == CH_BACKSLASH)
                    begin
                        mode_next = M_STRING_ESC;
                    end
                end
                M_STRING_ESC:
                begin
                    mode_next = M_STRING;
                end
                M_GT:
                begin
                    mode_next = M_IDLE;
                    first_v   = 1'b1;
                    if (char_code == CH_EQ)
                    begin
                        first = make_res(K_SYMBOL, S_GE, tstart16, 16'd2, 1'b0, E_NONE);
                    end
                    else
                    begin
                        first = make_res(K_SYMBOL, S_GT, tstart16, 16'd1, 1'b0, E_NONE);
                        again = 1'b1;
                    end
                end
                M_LT:
                begin
                    mode_next = M_IDLE;
                    first_v   = 1'b1;
                    if (char_code == CH_EQ)
                    begin
                        first = make_res(K_SYMBOL, S_LE, tstart16, 16'd2, 1'b0, E_NONE);
                    end
                    else if (char_code == CH_GT)
                    begin
                        first = make_res(K_SYMBOL, S_NE_ANGLE, tstart16, 16'd2, 1'b0, E_NONE);
                    end
                    else
                    begin
                        first = make_res(K_SYMBOL, S_LT, tstart16, 16'd1, 1'b0, E_NONE);
                        again = 1'b1;
                    end
                end
                M_BANG:
                begin
                    if (char_code == CH_EQ)
                    begin
                        first_v   = 1'b1;
                        first     = make_res(K_SYMBOL, S_NE_BANG, tstart16, 16'd2, 1'b0,
                                             E_NONE);
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        second_v  = 1'b1;
                        second    = make_res(K_ERROR, S_COMMA, tstart16, 16'd0, 1'b0,
                                             E_INVALID);
                        mode_next = M_HALT;
                    end
                end
                default:
                begin
                    again = 1'b1;
                end
            endcase

            if (again)
            begin
                priority if (is_space(char_code))
                begin
                end
                else if (is_alpha(char_code) || (char_code == CH_UNDERSCORE))
                begin
                    mode_next   = M_IDENT;
                    tstart_next = pos;
                end
                else if (is_digit(char_code))
                begin
                    mode_next     = M_NUMBER;
                    seen_dot_next = 1'b0;
                    tstart_next   = pos;
                end
                else if ((char_code == CH_PLUS) || (char_code == CH_MINUS))
                begin
                    mode_next     = M_SIGN;
                    seen_dot_next = 1'b0;
                    tstart_next   = pos;
                end
                else if ((char_code == CH_SQUOTE) || (char_code == CH_DQUOTE))
                begin
                    mode_next       = M_STRING;
                    open_quote_next = (char_code == CH_DQUOTE);
                    tstart_next     = pos + POSITION_BITS'(1);
                end
                else if (char_code == CH_GT)
                begin
                    mode_next   = M_GT;
                    tstart_next = pos;
                end
                else if (char_code == CH_LT)
                begin
                    mode_next   = M_LT;
                    tstart_next = pos;
                end
                else if (char_code == CH_BANG)
                begin
                    mode_next   = M_BANG;
                    tstart_next = pos;
                end
                else if (sym_hit)
                begin
                    second_v = 1'b1;
                    second   = make_res(K_SYMBOL, sym_code, pos16, 16'd1, 1'b0, E_NONE);
                end
                else
                begin
                    second_v  = 1'b1;
                    second    = make_res(K_ERROR, S_COMMA, pos16, 16'd0, 1'b0, E_INVALID);
                    mode_next = M_HALT;
                end
            end

            if (mode_next != M_HALT)
            begin
                pos_next = pos + POSITION_BITS'(1);
            end
        end
    end

    always_comb
    begin
        res_count = 2'(first_v) + 2'(second_v);
        res0      = first_v ? first : second;
        res1      = second;
        if (first_v && second_v)
        begin
            res1.last = 1'b1;
        end
        else
        begin
            res0.last = 1'b1;
        end
    end

endmodule

// ===== src/sqltl_res_fifo.sv =====
// ----------------------------------------------------------------------------
// sqltl_res_fifo
// Small result queue that takes up to two tokens per cycle and gives one.
// ----------------------------------------------------------------------------
module sqltl_res_fifo (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [1:0]                           push_count,
    input  sqltl_pkg::result_t                   push0,
    input  sqltl_pkg::result_t                   push1,
    input  logic                                 pop,
    output sqltl_pkg::result_t                   head,
    output logic [sqltl_pkg::FIFO_CNT_W-1:0]     count
);
    import sqltl_pkg::*;

    result_t                 mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wptr_reg;
    logic [FIFO_PTR_W-1:0]   wptr_next;
    logic [FIFO_PTR_W-1:0]   rptr_reg;
    logic [FIFO_PTR_W-1:0]   rptr_next;
    logic [FIFO_CNT_W-1:0]   count_reg;
    logic [FIFO_CNT_W-1:0]   count_next;

    assign wptr_next  = wptr_reg + FIFO_PTR_W'(push_count);
    assign rptr_next  = rptr_reg + FIFO_PTR_W'(pop);
    assign count_next = count_reg + FIFO_CNT_W'(push_count) - FIFO_CNT_W'(pop);
    assign head       = mem[rptr_reg];
    assign count      = count_reg;

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            mem[wptr_reg] <= push0;
        end
        if (push_count == 2'd2)
        begin
            mem[wptr_reg + FIFO_PTR_W'(1)] <= push1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== src/sql_token_lexer_core.sv =====
// ----------------------------------------------------------------------------
// sql_token_lexer_core
// Streaming SQL tokenizer: query bytes in, token descriptors out.
// ----------------------------------------------------------------------------
// Channel  Dir  tdata                      tuser        tlast
// s_axis   in   [7:0] char_code            [0] action   -
// m_axis   out  [3:0] symbol_code,         [2:0]        last_result
//               [19:4] start_position,     token_kind
//               [35:20] token_length,
//               [36] has_fraction,
//               [38:37] error_code
//
// One word is taken per cycle into the input register; the lexer state and
// its tokens advance from that register. A word yields up to two tokens into
// a four-entry result queue; the output drains one token per cycle while
// m_axis_tready is high, so two-token words set the sustained rate when they
// run in a row. Input stalls only while the queue holds more than two tokens.
// Reset leaves the lexer between tokens at position zero with no clearing pass.
// ----------------------------------------------------------------------------
module sql_token_lexer_core #(
    parameter int POSITION_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // char_code
    input  logic [0:0]  s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // symbol_code, start_position, token_length,
                                        // has_fraction, error_code, zero pad
    output logic [2:0]  m_axis_tuser,   // token_kind
    output logic        m_axis_tlast    // last_result
);
    import sqltl_pkg::*;

    logic                     in_valid_reg;
    logic                     in_action_reg;
    logic [7:0]               in_char_reg;
    logic [MODE_W-1:0]        mode_reg;
    logic [MODE_W-1:0]        mode_next;
    logic [POSITION_BITS-1:0] tstart_reg;
    logic [POSITION_BITS-1:0] tstart_next;
    logic [POSITION_BITS-1:0] pos_reg;
    logic [POSITION_BITS-1:0] pos_next;
    logic                     seen_dot_reg;
    logic                     seen_dot_next;
    logic                     open_quote_reg;
    logic                     open_quote_next;
    logic [1:0]               res_count;
    result_t                  res0;
    result_t                  res1;
    result_t                  head;
    logic [FIFO_CNT_W-1:0]    fifo_count;
    logic                     advance;
    logic                     pop;

    assign advance       = in_valid_reg && (fifo_count <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign s_axis_tready = !in_valid_reg || advance;
    assign pop           = m_axis_tready && (fifo_count != '0);

    sqltl_step #(
        .POSITION_BITS (POSITION_BITS)
    ) u_step (
        .action          (in_action_reg),
        .char_code       (in_char_reg),
        .mode            (mode_reg),
        .tstart          (tstart_reg),
        .pos             (pos_reg),
        .seen_dot        (seen_dot_reg),
        .open_quote      (open_quote_reg),
        .mode_next       (mode_next),
        .tstart_next     (tstart_next),
        .pos_next        (pos_next),
        .seen_dot_next   (seen_dot_next),
        .open_quote_next (open_quote_next),
        .res_count       (res_count),
        .res0            (res0),
        .res1            (res1)
    );

    sqltl_res_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (advance ? res_count : 2'd0),
        .push0      (res0),
        .push1      (res1),
        .pop        (pop),
        .head       (head),
        .count      (fifo_count)
    );

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_action_reg <= s_axis_tuser[0];
            in_char_reg   <= s_axis_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            mode_reg       <= M_IDLE;
            tstart_reg     <= '0;
            pos_reg        <= '0;
            seen_dot_reg   <= 1'b0;
            open_quote_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                mode_reg       <= mode_next;
                tstart_reg     <= tstart_next;
                pos_reg        <= pos_next;
                seen_dot_reg   <= seen_dot_next;
                open_quote_reg <= open_quote_next;
            end
        end
    end

    assign m_axis_tvalid = (fifo_count != '0);
    assign m_axis_tdata  = {1'b0, head.err, head.frac, head.len, head.start, head.sym};
    assign m_axis_tuser  = head.kind;
    assign m_axis_tlast  = head.last;

endmodule
